@@ design/aexs_pkg.sv @@
// Shared types, constants and helpers for the audio exciter sample block.
// No dependencies; every other file imports this package.
package aexs_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 32;
  localparam int AMT_W      = 7;
  localparam int GAIN_W     = 14;
  localparam int MUL_W      = 36;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = 68;
  localparam int Y_W        = 32;
  localparam int NUM_W      = 87;
  localparam int DEN_W      = 64;
  localparam int QUO_W      = 35;
  localparam int CNT_W      = 6;
  localparam int EFF_W      = 36;
  localparam int SUM_W      = 37;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Hard-clamp scale: k2 = K2_BASE + a*K2_STEP_INT + (a+1)/2 in Q2.30
  localparam logic [31:0] K2_BASE     = 32'd1073634450;
  localparam logic [31:0] K2_STEP_INT = 32'd10737407;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 4'd0,
    REG_AMOUNT = 4'd1,
    REG_GAIN   = 4'd2,
    REG_B0     = 4'd3,
    REG_B1     = 4'd4,
    REG_B2     = 4'd5,
    REG_A1     = 4'd6,
    REG_A2     = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic                     mode;
    logic [AMT_W-1:0]         amount;
    logic [GAIN_W-1:0]        gain;
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MB0, ST_MB1, ST_MB2, ST_MA1, ST_MA2, ST_FACC, ST_ROUND,
    ST_SQ, ST_CLIP, ST_SNUM, ST_SAM, ST_SDEN, ST_DSTART, ST_DWAIT,
    ST_GMUL, ST_GSQ, ST_GDRY, ST_GDMUL, ST_GDFIN, ST_DONE
  } fsm_state_e;

  function automatic logic [31:0] k2_of(input logic [AMT_W-1:0] a);
    logic [31:0] half;
    half  = (32'(a) + 32'd1) >> 1;
    k2_of = K2_BASE + 32'(a) * K2_STEP_INT + half;
  endfunction

  function automatic logic [SAMPLE_W-1:0] sat_sample(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(2 ** (SAMPLE_W - 1) - 1);
    lo = -SUM_W'(2 ** (SAMPLE_W - 1));
    if (v > hi) begin
      sat_sample = hi[SAMPLE_W-1:0];
    end else if (v < lo) begin
      sat_sample = lo[SAMPLE_W-1:0];
    end else begin
      sat_sample = v[SAMPLE_W-1:0];
    end
  endfunction

endpackage

@@ design/aexs_if.sv @@
// Channel interfaces of the audio exciter: sample requests, results, config writes.
// Depends on aexs_pkg for widths.
interface aexs_in_if;
  import aexs_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       silent;
  modport source (output valid, sample_in, silent, input ready);
  modport sink   (input valid, sample_in, silent, output ready);
endinterface

interface aexs_out_if;
  import aexs_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mix_out;
  logic signed [SAMPLE_W-1:0] effect_out;
  modport source (output valid, mix_out, effect_out, input ready);
  modport sink   (input valid, mix_out, effect_out, output ready);
endinterface

interface aexs_cfg_if;
  import aexs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/aexs_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on aexs_pkg.
module aexs_mul
  import aexs_pkg::*;
(
  input  logic                     clk_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  // Register every product
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

@@ design/aexs_div.sv @@
// Restoring divider, one quotient bit per cycle, for the soft saturator.
// Depends on aexs_pkg for the request and response structs.
module aexs_div
  import aexs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [NUM_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0] low_q, low_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [NUM_W-1:0] shifted;
  logic             fits;

  // Bring down the next dividend bit and try the subtract
  assign shifted = {rem_q[NUM_W-2:0], low_q[QUO_W-1]};
  assign fits    = shifted >= NUM_W'(req_i.den);

  always_comb begin
    rem_d  = rem_q;
    low_d  = low_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = NUM_W'(req_i.num[NUM_W-1:QUO_W]);
      low_d  = req_i.num[QUO_W-1:0];
      quo_d  = '0;
      cnt_d  = CNT_W'(QUO_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? shifted - NUM_W'(req_i.den) : shifted;
      low_d = {low_q[QUO_W-2:0], 1'b0};
      quo_d = {quo_q[QUO_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

@@ design/aexs_core.sv @@
// Sequencer and datapath: biquad, shaper, gain and dry mix over the shared units.
// Depends on aexs_pkg, aexs_mul and aexs_div.
module aexs_core
  import aexs_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       silent_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output logic [SAMPLE_W-1:0]        mix_o,
  output logic [SAMPLE_W-1:0]        effect_o
);

  fsm_state_e state_q, state_d;

  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]   prod;
  div_req_t                   div_req;
  div_rsp_t                   div_rsp;

  logic signed [SAMPLE_W-1:0] x_q, x1_q, x2_q;
  logic signed [Y_W-1:0]      y_q, y1_q, y2_q, y_d;
  logic signed [ACC_W-1:0]    acc_q;
  logic [31:0]                k2_q;
  logic [DEN_W-1:0]           den_q;
  logic [NUM_W-1:0]           num_q;
  logic [QUO_W-1:0]           r_q;
  logic signed [EFF_W-1:0]    e_q;
  logic [32:0]                dry_q;
  logic [SAMPLE_W-1:0]        mix_q, eff_q;

  logic [Y_W-1:0]             m;
  logic [SAMPLE_W-1:0]        xm;
  logic signed [ACC_W-1:0]    rnd;
  logic signed [39:0]         sh;
  logic [64:0]                zsum;
  logic [QUO_W-1:0]           z;
  logic [49:0]                esum;
  logic [33:0]                emag;
  logic [32:0]                g25;
  logic [57:0]                dsum;
  logic [25:0]                dmag;
  logic signed [SUM_W-1:0]    dsig, mixsum;

  aexs_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .prod_o(prod));
  aexs_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));

  // Magnitudes of filter output and dry sample
  assign m  = y_q[Y_W-1] ? (~y_q + Y_W'(1)) : y_q;
  assign xm = x_q[SAMPLE_W-1] ? (~x_q + SAMPLE_W'(1)) : x_q;

  // Round half up at 28 fraction bits, saturate to 32 bits
  assign rnd = acc_q + ACC_W'(64'd1 << 27);
  assign sh  = rnd[ACC_W-1:28];
  always_comb begin
    if (sh[39:31] == {9{sh[39]}}) begin
      y_d = sh[31:0];
    end else begin
      y_d = sh[39] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  // Scaled magnitude for the hard clamp, rounded half up at 30 fraction bits
  assign zsum = {1'b0, prod[63:0]} + 65'(64'd1 << 29);
  assign z    = zsum[64:30];

  // Wet gain, dry factor and dry product rounding
  assign esum   = {1'b0, prod[48:0]} + 50'(32'h8000);
  assign emag   = esum[49:16];
  assign g25    = (33'(prod[27:0]) << 4) + (33'(prod[27:0]) << 3) + 33'(prod[27:0]);
  assign dsum   = {1'b0, prod[56:0]} + 58'(64'd1 << 31);
  assign dmag   = dsum[57:32];
  assign dsig   = x_q[SAMPLE_W-1] ? -SUM_W'({1'b0, dmag}) : SUM_W'({1'b0, dmag});
  assign mixsum = SUM_W'(e_q) + dsig;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = silent_i ? ST_DONE : ST_MB0;
      ST_MB0:    state_d = ST_MB1;
      ST_MB1:    state_d = ST_MB2;
      ST_MB2:    state_d = ST_MA1;
      ST_MA1:    state_d = ST_MA2;
      ST_MA2:    state_d = ST_FACC;
      ST_FACC:   state_d = ST_ROUND;
      ST_ROUND:  state_d = ST_SQ;
      ST_SQ:     state_d = cfg_i.mode ? ST_CLIP : ST_SNUM;
      ST_CLIP:   state_d = ST_GMUL;
      ST_SNUM:   state_d = ST_SAM;
      ST_SAM:    state_d = ST_SDEN;
      ST_SDEN:   state_d = ST_DSTART;
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT:  if (div_rsp.done) state_d = ST_GMUL;
      ST_GMUL:   state_d = ST_GSQ;
      ST_GSQ:    state_d = ST_GDRY;
      ST_GDRY:   state_d = ST_GDMUL;
      ST_GDMUL:  state_d = ST_GDFIN;
      ST_GDFIN:  state_d = ST_DONE;
      ST_DONE:   if (res_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Multiplier operands and unit controls
  always_comb begin
    mul_a         = '0;
    mul_b         = '0;
    div_req.start = (state_q == ST_DSTART);
    div_req.num   = num_q;
    div_req.den   = den_q;
    in_ready_o    = (state_q == ST_IDLE);
    res_valid_o   = (state_q == ST_DONE);
    unique case (state_q)
      ST_MB0: begin
        mul_a = MUL_W'(cfg_i.b0);
        mul_b = MUL_W'(x_q);
      end
      ST_MB1: begin
        mul_a = MUL_W'(cfg_i.b1);
        mul_b = MUL_W'(x1_q);
      end
      ST_MB2: begin
        mul_a = MUL_W'(cfg_i.b2);
        mul_b = MUL_W'(x2_q);
      end
      ST_MA1: begin
        mul_a = MUL_W'(cfg_i.a1);
        mul_b = MUL_W'(y1_q);
      end
      ST_MA2: begin
        mul_a = MUL_W'(cfg_i.a2);
        mul_b = MUL_W'(y2_q);
      end
      ST_SQ: begin
        mul_a = MUL_W'({1'b0, m});
        mul_b = cfg_i.mode ? MUL_W'({1'b0, k2_q}) : MUL_W'({1'b0, m});
      end
      ST_SNUM: begin
        mul_a = MUL_W'({1'b0, m});
        mul_b = MUL_W'({1'b0, m}) + (MUL_W'(cfg_i.amount) << (SAMPLE_W - 1));
      end
      ST_SAM: begin
        mul_a = MUL_W'(cfg_i.amount);
        mul_b = MUL_W'({1'b0, m});
      end
      ST_GMUL: begin
        mul_a = MUL_W'(r_q);
        mul_b = MUL_W'(cfg_i.gain);
      end
      ST_GSQ: begin
        mul_a = MUL_W'(cfg_i.gain);
        mul_b = MUL_W'(cfg_i.gain);
      end
      ST_GDMUL: begin
        mul_a = MUL_W'(xm);
        mul_b = MUL_W'(dry_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      x1_q    <= '0;
      x2_q    <= '0;
      y1_q    <= '0;
      y2_q    <= '0;
    end else begin
      state_q <= state_d;
      // Advance the filter history once per non-silent sample
      if (state_q == ST_ROUND) begin
        x1_q <= x_q;
        x2_q <= x1_q;
        y1_q <= y_d;
        y2_q <= y1_q;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        x_q   <= sample_i;
        k2_q  <= k2_of(cfg_i.amount);
        mix_q <= '0;
        eff_q <= '0;
      end
      ST_MB1:  acc_q <= prod[ACC_W-1:0];
      ST_MB2:  acc_q <= acc_q + prod[ACC_W-1:0];
      ST_MA1:  acc_q <= acc_q + prod[ACC_W-1:0];
      ST_MA2:  acc_q <= acc_q - prod[ACC_W-1:0];
      ST_FACC: acc_q <= acc_q - prod[ACC_W-1:0];
      ST_ROUND: y_q  <= y_d;
      ST_CLIP: r_q   <= (z > QUO_W'(1 << (SAMPLE_W - 1))) ? QUO_W'(1 << (SAMPLE_W - 1)) : z;
      ST_SNUM: den_q <= prod[DEN_W-1:0];
      ST_SAM:  num_q <= {prod[62:0], 24'd0};
      ST_SDEN: begin
        den_q <= den_q + (DEN_W'(prod[38:0]) << (SAMPLE_W - 1))
                 + (DEN_W'(1) << (2 * (SAMPLE_W - 1)))
                 - (DEN_W'(m) << (SAMPLE_W - 1));
      end
      ST_DWAIT: begin
        if (div_rsp.done) r_q <= QUO_W'((36'(div_rsp.quo) + 36'd1) >> 1);
      end
      ST_GSQ: e_q <= y_q[Y_W-1] ? -EFF_W'({2'b0, emag}) : EFF_W'({2'b0, emag});
      ST_GDRY: dry_q <= g25[32] ? 33'd0 : (33'd1 << 32) - g25;
      ST_GDFIN: begin
        mix_q <= sat_sample(mixsum);
        eff_q <= sat_sample(SUM_W'(e_q));
      end
      default: begin
      end
    endcase
  end

  assign mix_o    = mix_q;
  assign effect_o = eff_q;

  // Divider is only started when idle
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy) else $error("divider restarted while busy");

  // Silent sample goes straight to the result and keeps the filter history
  a_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && silent_i) |=>
      (state_q == ST_DONE && $stable(x1_q) && $stable(y1_q)))
    else $error("silent sample disturbed the filter");

  // Taken result frees the sequencer
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i) |=> state_q == ST_IDLE)
    else $error("sequencer did not release after result");

  // Hard clamp never exceeds unity
  a_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLIP) |=> r_q <= QUO_W'(1 << (SAMPLE_W - 1)))
    else $error("clamp magnitude above one");

endmodule

@@ design/audio_exciter_sample_top.sv @@
// Top level of the audio exciter: config registers, sequencer core, result register.
// Depends on aexs_pkg, aexs_if and aexs_core.
//
// One sample request runs through a direct-form-I biquad, a soft rational
// saturator or a hard clamp, and a wet/dry mix, all on one shared 36x36
// multiplier under a sequencer. A request in soft mode takes longer than in
// hard-clamp mode, as the 35 one-bit steps of the restoring divider lie on
// its path; a silent request goes straight to its result. The input is not
// ready while a sample is in work; a finished result waits in an output
// register so the next sample can start.
// Configuration is written through its own channel, which is always ready.
module audio_exciter_sample_top
  import aexs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  aexs_cfg_if.sink in_cfg,
  aexs_in_if.sink  in_smp,
  aexs_out_if.source out_res
);

  cfg_t                cfg_q;
  logic                res_valid, res_ready;
  logic [SAMPLE_W-1:0] mix, eff;
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_mix_q, out_eff_q;

  assign in_cfg.ready = 1'b1;

  // Configuration register writes; unknown indices drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= 1'b0;
      cfg_q.amount <= AMT_W'(100);
      cfg_q.gain   <= GAIN_W'(6554);
      cfg_q.b0     <= COEF_W'(268435456);
      cfg_q.b1     <= '0;
      cfg_q.b2     <= '0;
      cfg_q.a1     <= '0;
      cfg_q.a2     <= '0;
    end else if (in_cfg.valid) begin
      unique case (in_cfg.index)
        REG_MODE:   cfg_q.mode   <= in_cfg.data[0];
        REG_AMOUNT: cfg_q.amount <= in_cfg.data[AMT_W-1:0];
        REG_GAIN:   cfg_q.gain   <= in_cfg.data[GAIN_W-1:0];
        REG_B0:     cfg_q.b0     <= in_cfg.data[COEF_W-1:0];
        REG_B1:     cfg_q.b1     <= in_cfg.data[COEF_W-1:0];
        REG_B2:     cfg_q.b2     <= in_cfg.data[COEF_W-1:0];
        REG_A1:     cfg_q.a1     <= in_cfg.data[COEF_W-1:0];
        REG_A2:     cfg_q.a2     <= in_cfg.data[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  aexs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_smp.valid),
    .in_ready_o  (in_smp.ready),
    .sample_i    (in_smp.sample_in),
    .silent_i    (in_smp.silent),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .mix_o       (mix),
    .effect_o    (eff)
  );

  // Hold the result until the sink takes it
  assign res_ready = !out_valid_q || out_res.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_mix_q <= mix;
      out_eff_q <= eff;
    end
  end

  assign out_res.valid      = out_valid_q;
  assign out_res.mix_out    = out_mix_q;
  assign out_res.effect_out = out_eff_q;

endmodule

@@ sim/tb_audio_exciter_sample_top.sv @@
// Self-checking testbench for audio_exciter_sample_top: directed samples, then randomised phases.
// Depends on aexs_pkg, the channel interfaces and the block; results are checked by a local predictor.
module tb_audio_exciter_sample_top;
  import aexs_pkg::*;

  localparam int LIMIT_CYCLES = 900000;
  localparam int SETTLE_CYCLES = 120;
  localparam int NUM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 108;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED = 4'd12;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       sil;
    logic                       typed;
    logic signed [SAMPLE_W-1:0] mix;
    logic signed [SAMPLE_W-1:0] eff;
  } smp_row_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] mix;
    logic signed [SAMPLE_W-1:0] eff;
  } mix_pair_t;

  logic clk_i;
  logic rst_ni;

  aexs_cfg_if in_cfg ();
  aexs_in_if  in_smp ();
  aexs_out_if out_res ();

  audio_exciter_sample_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_cfg (in_cfg),
    .in_smp (in_smp),
    .out_res(out_res)
  );

  // Predictor copy of the registers and the filter history
  logic                     p_mode;
  logic [AMT_W-1:0]         p_amount;
  logic [GAIN_W-1:0]        p_gain;
  logic signed [COEF_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [SAMPLE_W-1:0] hist_x1, hist_x2;
  logic signed [Y_W-1:0]      hist_y1, hist_y2;

  mix_pair_t pending_mix_q[$];
  int        fail_cnt = 0;
  int        res_cnt = 0;
  int        cyc_cnt = 0;
  logic      quiet;

  // Clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic logic signed [SAMPLE_W-1:0] clip_sample(input longint v);
    if (v > 64'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -64'sd8388608) begin
      return 24'sh800000;
    end
    return v[SAMPLE_W-1:0];
  endfunction

  // Work out the mix and effect samples of one request and advance the filter history
  task automatic exciter_predict(input logic signed [SAMPLE_W-1:0] smp, input logic sil,
                                 output logic signed [SAMPLE_W-1:0] mix,
                                 output logic signed [SAMPLE_W-1:0] eff);
    logic signed [127:0] acc;
    logic signed [127:0] sh;
    longint              prod;
    logic signed [Y_W-1:0] y;
    logic [127:0] mw, aw, sw, den, num, dk;
    logic [63:0]  m, k2, z, q, r, eu, dq, dry, xm, dm;
    longint       es, ds;
    acc = 0;
    if (sil) begin
      mix = '0;
      eff = '0;
      return;
    end
    // Biquad, direct form I, exact sum
    prod = longint'(p_b0) * longint'(smp);     acc = acc + prod;
    prod = longint'(p_b1) * longint'(hist_x1); acc = acc + prod;
    prod = longint'(p_b2) * longint'(hist_x2); acc = acc + prod;
    prod = longint'(p_a1) * longint'(hist_y1); acc = acc - prod;
    prod = longint'(p_a2) * longint'(hist_y2); acc = acc - prod;
    sh = (acc + (128'sd1 <<< 27)) >>> 28;
    if (sh > 128'sd2147483647) begin
      y = 32'sh7FFFFFFF;
    end else if (sh < -128'sd2147483648) begin
      y = 32'sh80000000;
    end else begin
      y = sh[31:0];
    end
    hist_x2 = hist_x1;
    hist_x1 = smp;
    hist_y2 = hist_y1;
    hist_y1 = y;

    // Shaper on the magnitude
    m = (y < 0) ? 64'(-longint'(y)) : 64'(y);
    if (p_mode) begin
      k2 = 64'd1073634450 + (64'(p_amount) * 64'd1073740750 + 64'd50) / 64'd100;
      z  = (m * k2 + (64'd1 << 29)) >> 30;
      r  = (z > (64'd1 << 23)) ? (64'd1 << 23) : z;
    end else begin
      mw  = 128'(m);
      aw  = 128'(p_amount);
      sw  = 128'd1 << 23;
      den = mw * mw + aw * mw * sw + sw * sw - mw * sw;
      num = (mw * (mw + aw * sw)) << 24;
      q   = '0;
      for (int k = 34; k >= 0; k--) begin
        dk = den << k;
        if (num >= dk) begin
          num  = num - dk;
          q[k] = 1'b1;
        end
      end
      r = (q + 64'd1) >> 1;
    end

    // Wet gain and derived dry gain, rounding away from zero
    eu = (r * 64'(p_gain) + 64'h8000) >> 16;
    es = (y < 0) ? -longint'(eu) : longint'(eu);
    dq = 64'd25 * 64'(p_gain) * 64'(p_gain);
    dry = (dq >= (64'd1 << 32)) ? 64'd0 : (64'd1 << 32) - dq;
    xm = (smp < 0) ? 64'(-longint'(smp)) : 64'(smp);
    dm = (xm * dry + (64'd1 << 31)) >> 32;
    ds = (smp < 0) ? -longint'(dm) : longint'(dm);
    mix = clip_sample(es + ds);
    eff = clip_sample(es);
  endtask

  // Write one register and mirror it in the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_cfg.valid <= 1'b1;
    in_cfg.index <= idx;
    in_cfg.data  <= val;
    do @(posedge clk_i); while (!in_cfg.ready);
    in_cfg.valid <= 1'b0;
    case (idx)
      REG_MODE:   p_mode   = val[0];
      REG_AMOUNT: p_amount = val[AMT_W-1:0];
      REG_GAIN:   p_gain   = val[GAIN_W-1:0];
      REG_B0:     p_b0     = val;
      REG_B1:     p_b1     = val;
      REG_B2:     p_b2     = val;
      REG_A1:     p_a1     = val;
      REG_A2:     p_a2     = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic md, input logic [AMT_W-1:0] amt,
                           input logic [GAIN_W-1:0] gn, input logic [31:0] b0,
                           input logic [31:0] b1, input logic [31:0] b2,
                           input logic [31:0] a1, input logic [31:0] a2);
    write_reg(REG_MODE, 32'(md));
    write_reg(REG_AMOUNT, 32'(amt));
    write_reg(REG_GAIN, 32'(gn));
    write_reg(REG_B0, b0);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
    write_reg(IDX_UNUSED, $urandom());
  endtask

  // Offer one sample request and queue its expected outputs once taken
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic sil,
                             input logic typed, input logic signed [SAMPLE_W-1:0] tmix,
                             input logic signed [SAMPLE_W-1:0] teff);
    mix_pair_t pr;
    logic signed [SAMPLE_W-1:0] pm, pe;
    in_smp.valid     <= 1'b1;
    in_smp.sample_in <= smp;
    in_smp.silent    <= sil;
    do @(posedge clk_i); while (!in_smp.ready);
    exciter_predict(smp, sil, pm, pe);
    pr.mix = typed ? tmix : pm;
    pr.eff = typed ? teff : pe;
    pending_mix_q.push_back(pr);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_smp.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // Hold the sender until every expected result is back, then let the block settle
  task automatic drain_results();
    in_smp.valid <= 1'b0;
    while (pending_mix_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2, 3: return SAMPLE_W'($signed($urandom_range(0, 2047)) - 1024);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] rand_coef(input logic wild);
    if (wild) begin
      return $urandom();
    end
    return 32'($signed($urandom_range(0, 32'h1FFFFFFF)) - 32'sh10000000);
  endfunction

  // Receiver: random stalls, one long hold-off once a few hundred results are in
  int  stall_left = 0;
  int  hold_left = 0;
  logic hold_done = 1'b0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_res.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_res.ready <= 1'b0;
    end else if (!hold_done && res_cnt >= 300) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_res.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_res.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_res.ready <= 1'b0;
    end else begin
      out_res.ready <= 1'b1;
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    mix_pair_t ex;
    if (rst_ni && out_res.valid && out_res.ready) begin
      res_cnt = res_cnt + 1;
      if (pending_mix_q.size() == 0) begin
        $error("unexpected result: mix_out %0d effect_out %0d",
               out_res.mix_out, out_res.effect_out);
        fail_cnt = fail_cnt + 1;
      end else begin
        ex = pending_mix_q.pop_front();
        if (out_res.mix_out !== ex.mix) begin
          $error("mix_out: expected %0d, got %0d", ex.mix, out_res.mix_out);
          fail_cnt = fail_cnt + 1;
        end
        if (out_res.effect_out !== ex.eff) begin
          $error("effect_out: expected %0d, got %0d", ex.eff, out_res.effect_out);
          fail_cnt = fail_cnt + 1;
        end
      end
    end
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cyc_cnt = cyc_cnt + 1;
    if (cyc_cnt > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Directed samples at reset settings: zero and silent outputs are known at a glance
  smp_row_t directed_rows[] = '{
    '{24'sd0,        1'b0, 1'b1, 24'sd0, 24'sd0},
    '{24'sh7FFFFF,   1'b1, 1'b1, 24'sd0, 24'sd0},
    '{24'sh7FFFFF,   1'b0, 1'b0, 24'sd0, 24'sd0},
    '{24'sh800000,   1'b0, 1'b0, 24'sd0, 24'sd0},
    '{24'sh800000,   1'b1, 1'b1, 24'sd0, 24'sd0},
    '{24'sd1,        1'b0, 1'b0, 24'sd0, 24'sd0},
    '{-24'sd1,       1'b0, 1'b0, 24'sd0, 24'sd0},
    '{24'sd4194304,  1'b0, 1'b0, 24'sd0, 24'sd0},
    '{-24'sd4194304, 1'b0, 1'b0, 24'sd0, 24'sd0},
    '{24'sh555555,   1'b0, 1'b0, 24'sd0, 24'sd0},
    '{24'shAAAAAA,   1'b0, 1'b0, 24'sd0, 24'sd0},
    '{24'sd0,        1'b1, 1'b1, 24'sd0, 24'sd0},
    '{24'sd838861,   1'b0, 1'b0, 24'sd0, 24'sd0}
  };

  initial begin
    logic wild;
    quiet = 1'b0;
    rst_ni = 1'b0;
    in_cfg.valid = 1'b0;
    in_cfg.index = '0;
    in_cfg.data = '0;
    in_smp.valid = 1'b0;
    in_smp.sample_in = '0;
    in_smp.silent = 1'b0;
    p_mode = 1'b0;
    p_amount = 7'd100;
    p_gain = 14'd6554;
    p_b0 = 32'sd268435456;
    p_b1 = '0;
    p_b2 = '0;
    p_a1 = '0;
    p_a2 = '0;
    hist_x1 = '0;
    hist_x2 = '0;
    hist_y1 = '0;
    hist_y2 = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].smp, directed_rows[i].sil, directed_rows[i].typed,
                  directed_rows[i].mix, directed_rows[i].eff);
    end
    drain_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        // hard clamp, no drive, no wet gain
        0: write_all(1'b1, 7'd0, 14'd0, 32'sd268435456, 32'd0, 32'd0, 32'd0, 32'd0);
        // hard clamp at top drive and gain, filter driven into saturation
        1: write_all(1'b1, 7'd127, 14'd16383, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                     32'h80000000, 32'h7FFFFFFF);
        // soft shaper, no drive, nominal maximum gain, a plain high-pass
        2: write_all(1'b0, 7'd0, 14'd13107, 32'sd241591910, -32'sd483183820,
                     32'sd241591910, -32'sd429496730, 32'sd171798692);
        // soft shaper at top drive with the extreme negative coefficients
        3: write_all(1'b0, 7'd127, 14'd16383, 32'h80000000, 32'h80000000, 32'h80000000,
                     32'h80000000, 32'h80000000);
        default: begin
          wild = ($urandom_range(0, 3) == 0);
          write_all(1'($urandom_range(0, 1)),
                    AMT_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                       : $urandom_range(0, 100)),
                    GAIN_W'(($urandom_range(0, 4) == 0) ? $urandom()
                                                        : $urandom_range(0, 13107)),
                    rand_coef(wild), rand_coef(wild), rand_coef(wild),
                    rand_coef(wild), rand_coef(wild));
        end
      endcase
      // last phase runs at full rate on both sides
      if (ph == NUM_PHASES - 1) begin
        quiet = 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_sample(rand_sample(), $urandom_range(0, 9) == 0, 1'b0, '0, '0);
      end
      drain_results();
    end

    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/aexs_pkg.sv
design/aexs_if.sv
design/aexs_mul.sv
design/aexs_div.sv
design/aexs_core.sv
design/audio_exciter_sample_top.sv
sim/tb_audio_exciter_sample_top.sv
